// ===== rtl/salsa_pkg.sv =====
// Salsa20 keystream XOR: shared types, constants and helper functions.
// No dependencies; imported by the controller, the datapath and the top level.
package salsa_pkg;

	localparam logic [31:0] SIGMA0       = 32'h61707865;
	localparam logic [31:0] SIGMA1_SHORT = 32'h3120646e;
	localparam logic [31:0] SIGMA1_LONG  = 32'h3320646e;
	localparam logic [31:0] SIGMA2_SHORT = 32'h79622d36;
	localparam logic [31:0] SIGMA2_LONG  = 32'h79622d32;
	localparam logic [31:0] SIGMA3       = 32'h6b206574;

	localparam logic [4:0] DROUNDS_RESET = 5'd10;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;
	typedef logic [3:0] widx_t;

	// word indices of the four quarter rounds, roles a, b, c, d
	localparam widx_t COL_IDX [4][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1},
		'{4'd10, 4'd14, 4'd2,  4'd6},
		'{4'd15, 4'd3,  4'd7,  4'd11}
	};
	localparam widx_t ROW_IDX [4][4] = '{
		'{4'd0,  4'd1,  4'd2,  4'd3},
		'{4'd5,  4'd6,  4'd7,  4'd4},
		'{4'd10, 4'd11, 4'd8,  4'd9},
		'{4'd15, 4'd12, 4'd13, 4'd14}
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL
	} state_t;

	typedef enum logic [2:0] {
		CFG_KEY0,
		CFG_KEY1,
		CFG_KEY2,
		CFG_KEY3,
		CFG_KEY_LONG,
		CFG_NONCE,
		CFG_DROUNDS
	} cfg_idx_t;

	typedef struct packed {
		logic [63:0] key0;
		logic [63:0] key1;
		logic [63:0] key2;
		logic [63:0] key3;
		logic        key_long;
		logic [63:0] nonce;
		logic [4:0]  drounds;
	} cfg_t;

	typedef struct packed {
		logic       start;
		logic       direct;
		logic       load;
		logic       round;
		logic       half;
		logic [1:0] qstep;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic need_block;
		logic out_free;
	} sts_t;

	function automatic word_t rot_step(word_t v, logic [1:0] step);
		word_t r;
		case (step)
			2'd0:    r = {v[24:0], v[31:25]};
			2'd1:    r = {v[22:0], v[31:23]};
			2'd2:    r = {v[18:0], v[31:19]};
			default: r = {v[13:0], v[31:14]};
		endcase
		return r;
	endfunction

	function automatic block_t init_block(cfg_t c, logic [63:0] ctr);
		block_t b;
		logic [63:0] hi0;
		logic [63:0] hi1;
		hi0 = c.key_long ? c.key2 : c.key0;
		hi1 = c.key_long ? c.key3 : c.key1;
		b[0]  = SIGMA0;
		b[1]  = c.key0[31:0];
		b[2]  = c.key0[63:32];
		b[3]  = c.key1[31:0];
		b[4]  = c.key1[63:32];
		b[5]  = c.key_long ? SIGMA1_LONG : SIGMA1_SHORT;
		b[6]  = c.nonce[31:0];
		b[7]  = c.nonce[63:32];
		b[8]  = ctr[31:0];
		b[9]  = ctr[63:32];
		b[10] = c.key_long ? SIGMA2_LONG : SIGMA2_SHORT;
		b[11] = hi0[31:0];
		b[12] = hi0[63:32];
		b[13] = hi1[31:0];
		b[14] = hi1[63:32];
		b[15] = SIGMA3;
		return b;
	endfunction

	function automatic logic [7:0] pick_byte(word_t w, logic [1:0] sel);
		logic [7:0] r;
		case (sel)
			2'd0:    r = w[7:0];
			2'd1:    r = w[15:8];
			2'd2:    r = w[23:16];
			default: r = w[31:24];
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/salsa_if.sv =====
// Valid/ready stream channels for the Salsa20 keystream XOR block.
// Input beat carries a data byte and the restart flag; output beat a data byte.
interface salsa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       restart;

	modport source (output valid, output data_in, output restart, input ready);
	modport sink   (input valid, input data_in, input restart, output ready);
endinterface

interface salsa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;

	modport source (output valid, output data_out, input ready);
	modport sink   (input valid, input data_out, output ready);
endinterface

// ===== rtl/salsa_ctrl.sv =====
// Salsa20 keystream XOR controller: accept, block load, round sequencing, finish.
// Depends on salsa_pkg; drives the datapath through cmd_t, observes sts_t.
module salsa_ctrl
	import salsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] drounds,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [4:0] dr_cnt_q;
	logic [2:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dr_cnt_q <= '0;
			step_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				dr_cnt_q <= drounds;
				step_q   <= '0;
			end else if (cmd.round) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) begin
					dr_cnt_q <= dr_cnt_q - 5'd1;
				end
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (sts.need_block) begin
						cmd.start = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						cmd.direct = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = (drounds == 5'd0) ? ST_FINAL : ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.half  = step_q[2];
				cmd.qstep = step_q[1:0];
				if (step_q == 3'd7 && dr_cnt_q == 5'd1) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("block finished while output register still held");
	a_load_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> $past(state_q) == ST_IDLE)
		else $error("block load not preceded by an accept");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.direct, cmd.load, cmd.round, cmd.finish}))
		else $error("more than one datapath command at once");
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && step_q == 3'd7 && dr_cnt_q == 5'd1) |=> state_q == ST_FINAL)
		else $error("round sequence overran its count");
`endif

endmodule

// ===== rtl/salsa_dp.sv =====
// Salsa20 keystream XOR datapath: state words, quarter-round step unit,
// block counter, byte position and output register. Depends on salsa_pkg.
module salsa_dp
	import salsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  logic [7:0] data_in,
	input  logic       restart,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out
);

	block_t      x_q;
	block_t      x_rnd;
	block_t      x_fin;
	block_t      init;
	logic [63:0] ctr_q;
	logic [5:0]  pos_q;
	logic [7:0]  data_q;
	logic        out_valid_q;
	logic [7:0]  out_data_q;

	assign init = init_block(cfg, ctr_q);

	always_comb begin
		word_t      quad [4];
		word_t      sum;
		logic [1:0] tgt;
		logic [1:0] op2;
		widx_t      idx;
		x_rnd = x_q;
		tgt   = cmd.qstep + 2'd1;
		op2   = cmd.qstep + 2'd3;
		for (int q = 0; q < 4; q++) begin
			for (int r = 0; r < 4; r++) begin
				quad[r] = cmd.half ? x_q[ROW_IDX[q][r]] : x_q[COL_IDX[q][r]];
			end
			sum      = quad[cmd.qstep] + quad[op2];
			idx      = cmd.half ? ROW_IDX[q][tgt] : COL_IDX[q][tgt];
			x_rnd[idx] = quad[tgt] ^ rot_step(sum, cmd.qstep);
		end
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			x_fin[i] = x_q[i] + init[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= init;
		end else if (cmd.round) begin
			x_q <= x_rnd;
		end else if (cmd.finish) begin
			x_q <= x_fin;
		end
		if (cmd.start) begin
			data_q <= data_in;
		end
		if (cmd.direct) begin
			out_data_q <= data_in ^ pick_byte(x_q[pos_q[5:2]], pos_q[1:0]);
		end else if (cmd.finish) begin
			out_data_q <= data_q ^ x_fin[0][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start && restart) begin
				ctr_q <= '0;
			end else if (cmd.finish) begin
				ctr_q <= ctr_q + 64'd1;
			end
			if (cmd.finish) begin
				pos_q <= 6'd1;
			end else if (cmd.direct) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.direct || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.need_block = restart || (pos_q == 6'd0);
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign data_out       = out_data_q;

endmodule

// ===== rtl/salsa20_keystream_xor_top.sv =====
// Salsa20 keystream XOR top level: configuration registers, controller, datapath.
// A byte inside a block goes straight to the output register at accept, one byte per cycle
// while the output register is free. A byte at block start waits for the block load, the
// rounds (one quarter-round step per cycle on the shared step unit) and the finish step.
// arst_n clears the configuration to its defaults, the block counter, the byte position
// and the controller; the keystream words are not cleared and are rebuilt before use.
module salsa20_keystream_xor_top
	import salsa_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wen,
	input  logic [2:0]    cfg_index,
	input  logic [63:0]   cfg_data,
	salsa_in_if.sink      in_ch,
	salsa_out_if.source   out_ch
);

	cfg_t cfg_q;
	sts_t sts;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{key0: 64'd0, key1: 64'd0, key2: 64'd0, key3: 64'd0,
				key_long: 1'b1, nonce: 64'd0, drounds: DROUNDS_RESET};
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY0:     cfg_q.key0     <= cfg_data;
				CFG_KEY1:     cfg_q.key1     <= cfg_data;
				CFG_KEY2:     cfg_q.key2     <= cfg_data;
				CFG_KEY3:     cfg_q.key3     <= cfg_data;
				CFG_KEY_LONG: cfg_q.key_long <= cfg_data[0];
				CFG_NONCE:    cfg_q.nonce    <= cfg_data;
				CFG_DROUNDS:  cfg_q.drounds  <= cfg_data[4:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	salsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.drounds  (cfg_q.drounds),
		.sts      (sts),
		.cmd      (cmd)
	);

	salsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.data_in   (in_ch.data_in),
		.restart   (in_ch.restart),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.data_out  (out_ch.data_out)
	);

endmodule

// ===== verif/tb_salsa20_keystream_xor_top.sv =====
`timescale 1ns / 100ps
// Testbench for salsa20_keystream_xor_top: directed table, then random phases of byte beats.
// Depends on rtl/salsa_pkg.sv, rtl/salsa_if.sv, the top level; predicts bytes no row fixes.
module tb_salsa20_keystream_xor_top;
	import salsa_pkg::*;

	localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;
	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_BEATS = 1800;

	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  idx;
		logic [63:0] value;
		logic [7:0]  data;
		logic        restart;
		logic        fixed;
		logic [7:0]  want;
	} row_t;

	localparam row_t DIRECTED_ROWS [30] = '{
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b1, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'hff, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_DROUNDS, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b1, 1'b1, 8'hca},
		'{1'b0, 3'd0, 64'd0, 8'hff, 1'b0, 1'b1, 8'h0f},
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'he0},
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b0, 1'b1, 8'hc2},
		'{1'b1, CFG_KEY0, ALL_ONES, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h5a, 1'b0, 1'b1, 8'h5a},
		'{1'b0, 3'd0, 64'd0, 8'ha5, 1'b1, 1'b0, 8'h00},
		'{1'b1, CFG_KEY_LONG, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b1, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h81, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_KEY1, ALL_ONES, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_KEY2, 64'h0123_4567_89ab_cdef, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_KEY3, 64'hfedc_ba98_7654_3210, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_NONCE, ALL_ONES, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_DROUNDS, 64'd31, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h3c, 1'b1, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'hc3, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_DROUNDS, 64'd17, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h81, 1'b1, 1'b0, 8'h00},
		'{1'b1, CFG_IDX_UNUSED, ALL_ONES, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_KEY_LONG, 64'd1, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_DROUNDS, 64'd1, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h7e, 1'b1, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b1, CFG_DROUNDS, 64'd16, 8'h00, 1'b0, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'hff, 1'b1, 1'b0, 8'h00},
		'{1'b0, 3'd0, 64'd0, 8'h55, 1'b0, 1'b0, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	salsa_in_if in_ch ();
	salsa_out_if out_ch ();

	salsa20_keystream_xor_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	cfg_t cfg_shadow;
	logic [63:0] blk_ctr;
	logic [5:0] byte_pos;
	word_t ks_words [16];
	logic [7:0] pending_bytes [$];
	int mismatches = 0;
	int stuck = 0;
	bit in_gaps = 1'b1;
	bit out_gaps = 1'b1;
	bit stall_request = 1'b0;

	function automatic word_t rotl(word_t v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void quarter(inout word_t x [16], input int a, int b, int c, int d);
		x[b] ^= rotl(x[a] + x[d], 7);
		x[c] ^= rotl(x[b] + x[a], 9);
		x[d] ^= rotl(x[c] + x[b], 13);
		x[a] ^= rotl(x[d] + x[c], 18);
	endfunction

	function automatic void next_keystream_block();
		word_t seed [16];
		word_t x [16];
		logic [63:0] hi0;
		logic [63:0] hi1;
		hi0 = cfg_shadow.key_long ? cfg_shadow.key2 : cfg_shadow.key0;
		hi1 = cfg_shadow.key_long ? cfg_shadow.key3 : cfg_shadow.key1;
		seed[0] = SIGMA0;
		seed[1] = cfg_shadow.key0[31:0];
		seed[2] = cfg_shadow.key0[63:32];
		seed[3] = cfg_shadow.key1[31:0];
		seed[4] = cfg_shadow.key1[63:32];
		seed[5] = cfg_shadow.key_long ? SIGMA1_LONG : SIGMA1_SHORT;
		seed[6] = cfg_shadow.nonce[31:0];
		seed[7] = cfg_shadow.nonce[63:32];
		seed[8] = blk_ctr[31:0];
		seed[9] = blk_ctr[63:32];
		seed[10] = cfg_shadow.key_long ? SIGMA2_LONG : SIGMA2_SHORT;
		seed[11] = hi0[31:0];
		seed[12] = hi0[63:32];
		seed[13] = hi1[31:0];
		seed[14] = hi1[63:32];
		seed[15] = SIGMA3;
		x = seed;
		for (int r = 0; r < int'(cfg_shadow.drounds); r++) begin
			quarter(x, 0, 4, 8, 12);
			quarter(x, 5, 9, 13, 1);
			quarter(x, 10, 14, 2, 6);
			quarter(x, 15, 3, 7, 11);
			quarter(x, 0, 1, 2, 3);
			quarter(x, 5, 6, 7, 4);
			quarter(x, 10, 11, 8, 9);
			quarter(x, 15, 12, 13, 14);
		end
		for (int i = 0; i < 16; i++)
			ks_words[i] = x[i] + seed[i];
		blk_ctr = blk_ctr + 64'd1;
	endfunction

	function automatic logic [7:0] keystream_xor(logic [7:0] d, logic restart);
		word_t w;
		if (restart) begin
			blk_ctr = '0;
			byte_pos = '0;
		end
		if (byte_pos == 6'd0)
			next_keystream_block();
		w = ks_words[byte_pos[5:2]] >> {byte_pos[1:0], 3'b000};
		byte_pos = byte_pos + 6'd1;
		return d ^ w[7:0];
	endfunction

	task automatic send_beat(input logic [7:0] d, input logic restart, input logic fixed,
			input logic [7:0] want);
		logic [7:0] guess;
		while (in_gaps && $urandom_range(99) < 16) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_in <= d;
		in_ch.restart <= restart;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		guess = keystream_xor(d, restart);
		pending_bytes.push_back(fixed ? want : guess);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_KEY0:     cfg_shadow.key0 = val;
			CFG_KEY1:     cfg_shadow.key1 = val;
			CFG_KEY2:     cfg_shadow.key2 = val;
			CFG_KEY3:     cfg_shadow.key3 = val;
			CFG_KEY_LONG: cfg_shadow.key_long = val[0];
			CFG_NONCE:    cfg_shadow.nonce = val;
			CFG_DROUNDS:  cfg_shadow.drounds = val[4:0];
			default: ;
		endcase
	endtask

	function automatic logic [63:0] pick_wide();
		case ($urandom_range(3))
			0:       return 64'd0;
			1:       return ALL_ONES;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic logic [63:0] pick_drounds();
		case ($urandom_range(5))
			0:       return 64'd0;
			1:       return 64'd1;
			2:       return 64'd16;
			3:       return 64'd31;
			default: return 64'($urandom_range(12, 1));
		endcase
	endfunction

	task automatic random_phase(input int ph, input int beats);
		settle();
		for (int i = 0; i < 7; i++) begin
			if ($urandom_range(9) < 6) begin
				case (i)
					CFG_KEY_LONG: cfg_write(CFG_KEY_LONG, 64'($urandom_range(1)));
					CFG_DROUNDS:  cfg_write(CFG_DROUNDS, pick_drounds());
					default:      cfg_write(3'(i), pick_wide());
				endcase
			end
		end
		if ($urandom_range(3) == 0)
			cfg_write(CFG_IDX_UNUSED, {$urandom(), $urandom()});
		in_gaps = (ph != 3);
		out_gaps = (ph != 3);
		if (ph == 5)
			stall_request = 1'b1;
		for (int i = 0; i < beats; i++)
			send_beat(8'($urandom()),
				(i == 0) ? 1'($urandom_range(1)) : ($urandom_range(49) == 0), 1'b0, 8'h00);
	endtask

	// receiver: random back-pressure, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ch.ready <= !(out_gaps && $urandom_range(99) < 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stuck <= 0;
			else
				stuck <= stuck + 1;
			if (stuck >= STALL_LIMIT) begin
				$display("salsa20_keystream_xor_top test failed");
				$finish;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (pending_bytes.size() == 0) begin
					$error("data_out: expected none, got %h", out_ch.data_out);
					mismatches++;
				end else if (out_ch.data_out !== pending_bytes[0]) begin
					$error("data_out: expected %h, got %h", pending_bytes[0], out_ch.data_out);
					mismatches++;
					void'(pending_bytes.pop_front());
				end else begin
					void'(pending_bytes.pop_front());
				end
			end
		end
	end

	initial begin
		int sent;
		int ph;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_in = '0;
		in_ch.restart = 1'b0;
		cfg_shadow = '0;
		cfg_shadow.key_long = 1'b1;
		cfg_shadow.drounds = DROUNDS_RESET;
		blk_ctr = '0;
		byte_pos = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			if (DIRECTED_ROWS[i].is_cfg) begin
				settle();
				cfg_write(DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].value);
			end else begin
				send_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].restart,
					DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
			end
		end

		sent = 0;
		ph = 0;
		while (sent < RANDOM_BEATS) begin
			int beats;
			beats = $urandom_range(220, 100);
			random_phase(ph, beats);
			sent += beats;
			ph++;
		end

		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("salsa20_keystream_xor_top test passed");
		else
			$display("salsa20_keystream_xor_top test failed");
		$finish;
	end

endmodule
